/* rtl/core/rv32i_instruction_execute_assert.svh */
// ----------------------------------------------------------------------------
// rv32i instruction execute assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RV32I_INSTRUCTION_EXECUTE_ASSERT_SVH

`ifndef SYNTHESIS

`define RVIE_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define RVIE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RVIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RVIE_ASSERT(label, clk, rst, cond, msg)
`define RVIE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RVIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/rvie_pkg.sv */
// ----------------------------------------------------------------------------
// rvie_pkg
// shared constants, codes and helpers of the rv32i execute block
// ----------------------------------------------------------------------------
`default_nettype none

package rvie_pkg;

   // data memory depth must be a power of two so addresses wrap by masking
   localparam int DMEM_WORDS_DEF = 1024;
   localparam int REG_COUNT_DEF  = 32;

   localparam logic [31:0] SP_RESET = 32'h7FFF_FFF0;
   localparam logic [31:0] GP_RESET = 32'h0000_000A;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_SB = 3'd0;
   localparam logic [2:0] F3_SH = 3'd1;
   localparam logic [2:0] F3_SW = 3'd2;

   localparam logic [1:0] TRAP_NONE    = 2'd0;
   localparam logic [1:0] TRAP_ILLEGAL = 2'd1;
   localparam logic [1:0] TRAP_ECALL   = 2'd2;
   localparam logic [1:0] TRAP_EBREAK  = 2'd3;

   // value of a register that was never written since reset
   function automatic logic [31:0] reg_reset_value(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd2:    v = SP_RESET;
         5'd3:    v = GP_RESET;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rvie_ram.sv */
// ----------------------------------------------------------------------------
// rvie_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rvie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/rv32i_instruction_execute.sv */
// results are registered after execute; a load reads registers in execute, then
// the data ram in the load stage. throughput: 1 item per cycle while not stalled;
// a load holds off the next item while in execute. results wait in an output
// register; a new item is taken while one waits. reset: synchronous; after reset
// a clearing pass zeroes every data ram word, during which no item is accepted
// ----------------------------------------------------------------------------
// rv32i_instruction_execute
// rv32i base integer execute: register file and data memory in rams
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv32i_instruction_execute_assert.svh"

module rv32i_instruction_execute
   import rvie_pkg::*;
#(
   parameter int DMEM_WORDS = DMEM_WORDS_DEF,
   parameter int REG_COUNT  = REG_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_reg_write,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic [1:0]       rsp_trap_kind
);

   localparam int AW  = $clog2(DMEM_WORDS);
   localparam int RIW = $clog2(REG_COUNT);
   localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);
   localparam logic [AW-1:0] CLR_LAST = AW'(DMEM_WORDS - 1);

   // ---------------- control registers
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          ex_valid_ff, ex_valid_in;
   logic [31:0]   ex_instr_ff;
   logic          ld_valid_ff, ld_valid_in;
   logic [31:0]   pc_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [REG_COUNT-1:0] reg_vld_ff;
   logic          fwd_en_ff;
   logic [4:0]    fwd_idx_ff;
   logic [31:0]   fwd_val_ff;

   // load stage payload
   logic          ld_wr_ff;
   logic [4:0]    ld_rd_ff;
   logic [2:0]    ld_f3_ff;
   logic [1:0]    ld_off_ff;
   logic [AW-1:0] ld_word_ff [4];

   // output payload
   logic [31:0] rsp_next_pc_ff;
   logic        rsp_reg_write_ff;
   logic [4:0]  rsp_reg_index_ff;
   logic [31:0] rsp_reg_value_ff;
   logic [1:0]  rsp_trap_kind_ff;

   logic req_accept, out_blocked, ex_fire, ex_done, ld_done;

   // ---------------- register file rams
   logic [31:0]    rf_rdata_a, rf_rdata_b;
   logic [31:0]    rd_src;
   logic           wb_en;
   logic [4:0]     wb_idx;
   logic [31:0]    wb_val;
   logic [31:0]    instr;

   assign instr  = ex_instr_ff;
   assign rd_src = req_accept ? req_instruction_word : ex_instr_ff;

   rvie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_idx[RIW-1:0]),
      .wr_data (wb_val),
      .rd_addr (rd_src[15+RIW-1:15]),
      .rd_data (rf_rdata_a)
   );

   rvie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_idx[RIW-1:0]),
      .wr_data (wb_val),
      .rd_addr (rd_src[20+RIW-1:20]),
      .rd_data (rf_rdata_b)
   );

   // x0 or out of range: zero; else forwarded last write, valid bit, reset value
   function automatic logic [31:0] reg_pick(input logic [4:0] idx, input logic [31:0] ram,
                                            input logic fen, input logic [4:0] fidx,
                                            input logic [31:0] fval, input logic vld);
      logic [31:0] v;
      if (idx == 5'd0 || {1'b0, idx} >= REG_LIMIT) v = 32'd0;
      else if (fen && fidx == idx)                  v = fval;
      else if (vld)                                 v = ram;
      else                                          v = reg_reset_value(idx);
      return v;
   endfunction

   logic [31:0] a, b;
   assign a = reg_pick(instr[19:15], rf_rdata_a, fwd_en_ff, fwd_idx_ff, fwd_val_ff,
                       reg_vld_ff[instr[15+RIW-1:15]]);
   assign b = reg_pick(instr[24:20], rf_rdata_b, fwd_en_ff, fwd_idx_ff, fwd_val_ff,
                       reg_vld_ff[instr[20+RIW-1:20]]);

   // ---------------- decode and execute
   logic [6:0]  op, f7;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
   assign op = instr[6:0];
   assign rd = instr[11:7];
   assign f3 = instr[14:12];
   assign f7 = instr[31:25];
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign imm_u = {instr[31:12], 12'd0};

   function automatic logic [31:0] alu(input logic [2:0] fn, input logic sub, input logic sra,
                                       input logic [31:0] x, input logic [31:0] y,
                                       input logic [4:0] sh);
      logic [31:0] r;
      case (fn)
         F3_ADD:  r = sub ? x - y : x + y;
         F3_SLL:  r = x << sh;
         F3_SLT:  r = {31'd0, $signed(x) < $signed(y)};
         F3_SLTU: r = {31'd0, x < y};
         F3_XOR:  r = x ^ y;
         F3_SR:   r = sra ? 32'($signed(x) >>> sh) : x >> sh;
         F3_OR:   r = x | y;
         default: r = x & y;
      endcase
      return r;
   endfunction

   logic [31:0] ex_val, ex_npc, pc_plus4;
   logic        ex_wr_raw, ex_wr, is_load, is_store, take;
   logic [1:0]  ex_trap;
   assign pc_plus4 = pc_ff + 32'd4;

   always_comb begin
      ex_val    = 32'd0;
      ex_wr_raw = 1'b0;
      ex_trap   = TRAP_NONE;
      ex_npc    = pc_plus4;
      is_load   = 1'b0;
      is_store  = 1'b0;
      take      = 1'b0;
      case (op)
         OPC_OP: begin
            if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
               ex_wr_raw = 1'b1;
               ex_val    = alu(f3, f7[5], f7[5], a, b, b[4:0]);
            end else begin
               ex_trap = TRAP_ILLEGAL;
            end
         end
         OPC_OPIMM: begin
            if ((f3 == F3_SLL && f7 != F7_BASE) ||
                (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) begin
               ex_trap = TRAP_ILLEGAL;
            end else begin
               ex_wr_raw = 1'b1;
               ex_val    = alu(f3, 1'b0, f7[5], a, imm_i, instr[24:20]);
            end
         end
         OPC_LOAD: begin
            if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
               is_load   = 1'b1;
               ex_wr_raw = 1'b1;
            end else begin
               ex_trap = TRAP_ILLEGAL;
            end
         end
         OPC_STORE: begin
            if (f3 == F3_SB || f3 == F3_SH || f3 == F3_SW) is_store = 1'b1;
            else                                          ex_trap  = TRAP_ILLEGAL;
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  take = (a == b);
               F3_BNE:  take = (a != b);
               F3_BLT:  take = $signed(a) < $signed(b);
               F3_BGE:  take = !($signed(a) < $signed(b));
               F3_BLTU: take = (a < b);
               F3_BGEU: take = (a >= b);
               default: ex_trap = TRAP_ILLEGAL;
            endcase
            if (take) ex_npc = pc_ff + imm_b;
         end
         OPC_JAL: begin
            ex_wr_raw = 1'b1;
            ex_val    = pc_plus4;
            ex_npc    = pc_ff + imm_j;
         end
         OPC_JALR: begin
            if (f3 != 3'd0) begin
               ex_trap = TRAP_ILLEGAL;
            end else begin
               ex_wr_raw = 1'b1;
               ex_val    = pc_plus4;
               ex_npc    = (a + imm_i) & ~32'd1;
            end
         end
         OPC_LUI: begin
            ex_wr_raw = 1'b1;
            ex_val    = imm_u;
         end
         OPC_AUIPC: begin
            ex_wr_raw = 1'b1;
            ex_val    = pc_ff + imm_u;
         end
         OPC_SYSTEM: begin
            if (instr == WORD_ECALL)       ex_trap = TRAP_ECALL;
            else if (instr == WORD_EBREAK) ex_trap = TRAP_EBREAK;
            else                           ex_trap = TRAP_ILLEGAL;
         end
         default: ex_trap = TRAP_ILLEGAL;
      endcase
   end

   assign ex_wr = ex_wr_raw && ex_trap == TRAP_NONE && rd != 5'd0 && {1'b0, rd} < REG_LIMIT;

   // ---------------- handshake
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign ex_fire     = ex_valid_ff && (is_load || !out_blocked);
   assign ex_done     = ex_fire && !is_load;
   assign ld_done     = ld_valid_ff && !out_blocked;
   assign req_stall   = clr_ff || (ex_valid_ff && !ex_done) || (ld_valid_ff && out_blocked);
   assign req_accept  = req_valid && !req_stall;

   // ---------------- data memory, one ram per byte lane
   logic [31:0]   mem_addr;
   logic [1:0]    off;
   logic [AW-1:0] wbase, wnext;
   logic [AW-1:0] lane_word [4];
   logic [7:0]    lane_rdata [4];

   assign mem_addr = a + (is_store ? imm_s : imm_i);
   assign off      = mem_addr[1:0];
   assign wbase    = mem_addr[AW+1:2];
   assign wnext    = wbase + AW'(1);

   for (genvar L = 0; L < 4; L++) begin : g_lane
      logic [1:0]    k;
      logic          incl;
      logic [AW-1:0] raddr, waddr;
      logic [7:0]    wdata;
      logic          we;

      assign lane_word[L] = (2'(L) >= off) ? wbase : wnext;
      assign k     = 2'(L) - off;
      assign incl  = (f3[1:0] == 2'd2) || (f3[1:0] == 2'd1 && !k[1]) || (k == 2'd0);
      assign wdata = clr_ff ? 8'd0 : 8'(b >> {k, 3'd0});
      assign waddr = clr_ff ? clr_cnt_ff : lane_word[L];
      assign we    = clr_ff || (ex_done && is_store && incl);
      assign raddr = (ex_valid_ff && is_load) ? lane_word[L] : ld_word_ff[L];

      rvie_ram #(.WIDTH(8), .DEPTH(DMEM_WORDS)) u_dmem (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (waddr),
         .wr_data (wdata),
         .rd_addr (raddr),
         .rd_data (lane_rdata[L])
      );
   end

   // load assembly: byte k of the item sits in lane (offset + k)
   logic [31:0] ld_raw, ld_val;
   assign ld_raw = {lane_rdata[ld_off_ff + 2'd3], lane_rdata[ld_off_ff + 2'd2],
                    lane_rdata[ld_off_ff + 2'd1], lane_rdata[ld_off_ff]};

   always_comb begin
      case (ld_f3_ff)
         F3_LB:   ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
         F3_LH:   ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
         F3_LBU:  ld_val = {24'd0, ld_raw[7:0]};
         F3_LHU:  ld_val = {16'd0, ld_raw[15:0]};
         default: ld_val = ld_raw;
      endcase
   end

   // ---------------- write-back
   assign wb_en  = (ex_done && ex_wr) || (ld_done && ld_wr_ff);
   assign wb_idx = ld_valid_ff ? ld_rd_ff : rd;
   assign wb_val = ld_valid_ff ? ld_val : ex_val;

   // ---------------- next state
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == CLR_LAST) clr_in = 1'b0;
      end
      ex_valid_in  = req_accept || (ex_valid_ff && !ex_fire);
      ld_valid_in  = (ex_fire && is_load) || (ld_valid_ff && out_blocked);
      rsp_valid_in = ex_done || ld_done || out_blocked;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         ex_valid_ff  <= 1'b0;
         ld_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 32'd0;
         reg_vld_ff   <= '0;
         fwd_en_ff    <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         ex_valid_ff  <= ex_valid_in;
         ld_valid_ff  <= ld_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_fire) pc_ff <= is_load ? pc_plus4 : ex_npc;
         if (wb_en) begin
            reg_vld_ff[wb_idx[RIW-1:0]] <= 1'b1;
            fwd_en_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) ex_instr_ff <= req_instruction_word;
      if (wb_en) begin
         fwd_idx_ff <= wb_idx;
         fwd_val_ff <= wb_val;
      end
      if (ex_fire && is_load) begin
         ld_wr_ff  <= ex_wr;
         ld_rd_ff  <= rd;
         ld_f3_ff  <= f3;
         ld_off_ff <= off;
         for (int i = 0; i < 4; i++) ld_word_ff[i] <= lane_word[i];
      end
      if (ex_done) begin
         rsp_next_pc_ff   <= ex_npc;
         rsp_reg_write_ff <= ex_wr;
         rsp_reg_index_ff <= ex_wr ? rd : 5'd0;
         rsp_reg_value_ff <= ex_wr ? ex_val : 32'd0;
         rsp_trap_kind_ff <= ex_trap;
      end else if (ld_done) begin
         rsp_next_pc_ff   <= pc_ff;
         rsp_reg_write_ff <= ld_wr_ff;
         rsp_reg_index_ff <= ld_wr_ff ? ld_rd_ff : 5'd0;
         rsp_reg_value_ff <= ld_wr_ff ? ld_val : 32'd0;
         rsp_trap_kind_ff <= TRAP_NONE;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_reg_write = rsp_reg_write_ff;
   assign rsp_reg_index = rsp_reg_index_ff;
   assign rsp_reg_value = rsp_reg_value_ff;
   assign rsp_trap_kind = rsp_trap_kind_ff;

   // ---------------- assertions
   `RVIE_ASSERT_IMP(a_no_accept_in_clear, clock, reset, clr_ff, req_stall, "item taken during clear")
   `RVIE_ASSERT(a_one_stage_busy, clock, reset, !(ex_valid_ff && ld_valid_ff), "ex and load both busy")
   `RVIE_ASSERT_IMP(a_no_x0_write, clock, reset, wb_en, wb_idx != 5'd0, "write to x0")
   `RVIE_ASSERT_NEXT(a_load_result, clock, reset, ld_done, rsp_valid_ff && !ld_valid_ff, "load item lost")

endmodule

`default_nettype wire
